// File: rtl/fpa_pkg.sv
// shared types, codes and saturation helper for the fixed-point alu
package fpa_pkg;

    typedef enum logic [4:0] {
        ACT_ADD      = 5'd0,
        ACT_SUB      = 5'd1,
        ACT_MUL      = 5'd2,
        ACT_DIV      = 5'd3,
        ACT_GT       = 5'd4,
        ACT_LT       = 5'd5,
        ACT_GE       = 5'd6,
        ACT_LE       = 5'd7,
        ACT_EQ       = 5'd8,
        ACT_NE       = 5'd9,
        ACT_MIN      = 5'd10,
        ACT_MAX      = 5'd11,
        ACT_INC      = 5'd12,
        ACT_DEC      = 5'd13,
        ACT_ABS      = 5'd14,
        ACT_FROM_INT = 5'd15,
        ACT_TO_INT   = 5'd16
    } t_action;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef struct packed {
        logic [4:0]  action;
        logic        neg;
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  st;
        logic [63:0] prod;
        logic [31:0] den;
    } t_ctl;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] res;
    } t_sat;

    function automatic t_sat f_sat(input logic [63:0] m, input logic neg);
        t_sat s;
        s.st  = ST_OK;
        s.res = '0;
        if (neg) begin
            if (m > {32'd0, MIN32}) begin
                s.st  = ST_OVERFLOW;
                s.res = MIN32;
            end else begin
                s.res = ~m[31:0] + 32'd1;
            end
        end else begin
            if (m > {32'd0, MAX32}) begin
                s.st  = ST_OVERFLOW;
                s.res = MAX32;
            end else begin
                s.res = m[31:0];
            end
        end
        return s;
    endfunction

endpackage

// File: rtl/fixed_point_alu.sv
// fixed-point alu top level: front stage, divider cell chain, output stage
// an accepted word passes the front stage register, each divider cell register and the output stage register
// throughput: one word per cycle while i_ready is high, set by the divider chain of 32 + FRAC_BITS cells
// each stage holds its word while stalled and takes a new one when it is empty or its successor moves
// reset: synchronous active-low i_rst_n clears every stage valid bit; no other state
module fixed_point_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [4:0]         i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result_value,
    output logic               o_compare_true,
    output logic [1:0]         o_status
);
    import fpa_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;

    logic             c_valid [0:NUM_W];
    logic             c_ready [0:NUM_W];
    t_ctl             c_ctl   [0:NUM_W];
    logic [NUM_W-1:0] c_num   [0:NUM_W];
    logic [NUM_W-1:0] c_quo   [0:NUM_W];
    logic [31:0]      c_rem   [0:NUM_W];

    fpa_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_operand_a, .i_operand_b,
        .o_valid(c_valid[0]), .i_ready(c_ready[0]),
        .o_ctl(c_ctl[0]), .o_num(c_num[0])
    );

    assign c_quo[0] = '0;
    assign c_rem[0] = '0;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        fpa_div_cell #(.NUM_W(NUM_W)) u_cell (
            .i_clk, .i_rst_n,
            .i_valid(c_valid[g]), .o_ready(c_ready[g]),
            .i_ctl(c_ctl[g]), .i_num(c_num[g]), .i_quo(c_quo[g]), .i_rem(c_rem[g]),
            .o_valid(c_valid[g+1]), .i_ready(c_ready[g+1]),
            .o_ctl(c_ctl[g+1]), .o_num(c_num[g+1]), .o_quo(c_quo[g+1]),
            .o_rem(c_rem[g+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(c_valid[NUM_W]), .o_ready(c_ready[NUM_W]),
        .i_ctl(c_ctl[NUM_W]), .i_quo(c_quo[NUM_W]), .i_rem(c_rem[NUM_W]),
        .o_valid, .i_ready, .o_result_value, .o_compare_true, .o_status
    );

`ifndef NO_ASSERTIONS
    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIV_ZERO |-> o_result_value == 32'd0 && !o_compare_true)
        else $error("division by zero word has nonzero payload");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result_value == 32'd0 && o_status == ST_OK)
        else $error("comparison word carries a value or status");
    a_ovf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OVERFLOW |-> o_result_value == MAX32 ||
        o_result_value == MIN32)
        else $error("overflow word not saturated");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");
`endif

endmodule

// File: rtl/fpa_front.sv
// input stage: magnitudes, product, simple actions and divider load
module fpa_front #(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [4:0]         i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output fpa_pkg::t_ctl      o_ctl,
    output logic [NUM_W-1:0]   o_num
);
    import fpa_pkg::*;

    logic             r_valid;
    t_ctl             r_ctl, n_ctl;
    logic [NUM_W-1:0] r_num, n_num;
    logic [31:0]      ma, mb;
    logic [32:0]      sum, dif;
    t_sat             sat;
    logic [63:0]      fi;

    assign o_ready = !r_valid || i_ready;
    assign ma = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
    assign mb = i_operand_b[31] ? (~i_operand_b + 32'd1) : i_operand_b;
    assign sum = {i_operand_a[31], i_operand_a} + {i_operand_b[31], i_operand_b};
    assign dif = {i_operand_a[31], i_operand_a} - {i_operand_b[31], i_operand_b};
    assign fi = 64'({ma, FRAC_BITS'(0)});

    always_comb begin
        n_ctl        = '0;
        n_ctl.action = i_action;
        n_ctl.neg    = i_operand_a[31] ^ i_operand_b[31];
        n_ctl.prod   = 64'(ma) * 64'(mb);
        n_ctl.den    = mb;
        n_num        = {ma, FRAC_BITS'(0)};
        sat          = f_sat(fi, i_operand_a[31]);
        unique case (t_action'(i_action))
            ACT_ADD: begin
                if (sum[32] != sum[31]) begin
                    n_ctl.st  = ST_OVERFLOW;
                    n_ctl.res = sum[32] ? MIN32 : MAX32;
                end else begin
                    n_ctl.res = sum[31:0];
                end
            end
            ACT_SUB: begin
                if (dif[32] != dif[31]) begin
                    n_ctl.st  = ST_OVERFLOW;
                    n_ctl.res = dif[32] ? MIN32 : MAX32;
                end else begin
                    n_ctl.res = dif[31:0];
                end
            end
            ACT_MUL: ;
            ACT_DIV: begin
                if (mb == 32'd0) n_ctl.st = ST_DIV_ZERO;
            end
            ACT_GT: n_ctl.cmp = i_operand_a > i_operand_b;
            ACT_LT: n_ctl.cmp = i_operand_a < i_operand_b;
            ACT_GE: n_ctl.cmp = i_operand_a >= i_operand_b;
            ACT_LE: n_ctl.cmp = i_operand_a <= i_operand_b;
            ACT_EQ: n_ctl.cmp = i_operand_a == i_operand_b;
            ACT_NE: n_ctl.cmp = i_operand_a != i_operand_b;
            ACT_MIN: n_ctl.res = (i_operand_a < i_operand_b) ? i_operand_a : i_operand_b;
            ACT_MAX: n_ctl.res = (i_operand_a > i_operand_b) ? i_operand_a : i_operand_b;
            ACT_INC: begin
                if (i_operand_a == MAX32) n_ctl.st = ST_OVERFLOW;
                n_ctl.res = (i_operand_a == MAX32) ? MAX32 : i_operand_a + 32'sd1;
            end
            ACT_DEC: begin
                if (i_operand_a == MIN32) n_ctl.st = ST_OVERFLOW;
                n_ctl.res = (i_operand_a == MIN32) ? MIN32 : i_operand_a - 32'sd1;
            end
            ACT_ABS: begin
                if (i_operand_a == MIN32) n_ctl.st = ST_OVERFLOW;
                n_ctl.res = (i_operand_a == MIN32) ? MAX32 : ma;
            end
            ACT_FROM_INT: begin
                n_ctl.st  = sat.st;
                n_ctl.res = sat.res;
            end
            ACT_TO_INT: begin
                n_ctl.res = i_operand_a[31] ? (~(ma >> FRAC_BITS) + 32'd1)
                                            : (ma >> FRAC_BITS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ctl <= n_ctl;
            r_num <= n_num;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_num   = r_num;

endmodule

// File: rtl/fpa_div_cell.sv
// one restoring divider cell: one quotient bit per stage
module fpa_div_cell #(
    parameter int NUM_W = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fpa_pkg::t_ctl    i_ctl,
    input  logic [NUM_W-1:0] i_num,
    input  logic [NUM_W-1:0] i_quo,
    input  logic [31:0]      i_rem,
    output logic             o_valid,
    input  logic             i_ready,
    output fpa_pkg::t_ctl    o_ctl,
    output logic [NUM_W-1:0] o_num,
    output logic [NUM_W-1:0] o_quo,
    output logic [31:0]      o_rem
);
    import fpa_pkg::*;

    logic             r_valid;
    t_ctl             r_ctl;
    logic [NUM_W-1:0] r_num, r_quo;
    logic [31:0]      r_rem;
    logic [31:0]      trial;
    logic             ge;

    assign o_ready = !r_valid || i_ready;
    assign trial   = {i_rem[30:0], i_num[NUM_W-1]};
    assign ge      = trial >= i_ctl.den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_num <= i_num << 1;
            r_quo <= {i_quo[NUM_W-2:0], ge};
            r_rem <= ge ? trial - i_ctl.den : trial;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_rem   = r_rem;

endmodule

// File: rtl/fpa_back.sv
// output stage: rounding and saturation of multiply and divide
module fpa_back #(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fpa_pkg::t_ctl      i_ctl,
    input  logic [NUM_W-1:0]   i_quo,
    input  logic [31:0]        i_rem,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result_value,
    output logic               o_compare_true,
    output logic [1:0]         o_status
);
    import fpa_pkg::*;

    logic        r_valid;
    logic [31:0] r_res, n_res;
    logic        r_cmp;
    logic [1:0]  r_st, n_st;
    logic        up;
    logic [NUM_W:0] qd;
    logic [64:0] pr;
    t_sat        sm, sd;

    assign o_ready = !r_valid || i_ready;
    assign up = {i_rem, 1'b0} >= {1'b0, i_ctl.den};
    assign qd = {1'b0, i_quo} + (NUM_W+1)'(up);
    assign pr = {1'b0, i_ctl.prod} + (65'd1 << (FRAC_BITS - 1));
    assign sm = f_sat(pr[64:FRAC_BITS] > 65'(64'hffff_ffff_ffff_ffff) ? '1 :
                      64'(pr >> FRAC_BITS), i_ctl.neg);
    assign sd = f_sat(64'(qd), i_ctl.neg);

    always_comb begin
        n_res = i_ctl.res;
        n_st  = i_ctl.st;
        if (t_action'(i_ctl.action) == ACT_MUL) begin
            n_res = sm.res;
            n_st  = sm.st;
        end else if (t_action'(i_ctl.action) == ACT_DIV && i_ctl.st != ST_DIV_ZERO) begin
            n_res = sd.res;
            n_st  = sd.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= n_res;
            r_cmp <= i_ctl.cmp;
            r_st  <= n_st;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_compare_true = r_cmp;
    assign o_status       = r_st;

endmodule

// File: tb/tb_fixed_point_alu.sv
// testbench for the fixed-point alu: random and directed words checked against a predictor
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int N_RANDOM = 1200;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  st;
    } t_alu_out;

    class alu_scoreboard;
        t_alu_out pending[$];
        int errors;
        int mismatches;

        function automatic logic [31:0] clamp64(input logic signed [63:0] v,
                                                inout logic [1:0] st);
            if (v > 64'sh7fff_ffff) begin
                st = ST_OVERFLOW;
                return MAX32;
            end
            if (v < -64'sh8000_0000) begin
                st = ST_OVERFLOW;
                return MIN32;
            end
            return v[31:0];
        endfunction

        function automatic t_alu_out compute(input logic [4:0] act,
                                             input logic signed [31:0] a32,
                                             input logic signed [31:0] b32);
            t_alu_out o;
            logic signed [63:0] a, b, r;
            logic [63:0] ma, mb, q, num, den;
            logic neg;
            a = a32;
            b = b32;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            neg = (a < 0) != (b < 0);
            r = 0;
            o = '0;
            o.st = ST_OK;
            case (act)
                ACT_ADD: r = a + b;
                ACT_SUB: r = a - b;
                ACT_MUL: begin
                    q = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    r = neg ? -$signed(q) : $signed(q);
                end
                ACT_DIV: begin
                    num = ma << FRAC_BITS;
                    den = mb;
                    if (b != 0) begin
                        q = (2 * num + den) / (2 * den);
                        r = neg ? -$signed(q) : $signed(q);
                    end
                end
                ACT_GT: o.cmp = a > b;
                ACT_LT: o.cmp = a < b;
                ACT_GE: o.cmp = a >= b;
                ACT_LE: o.cmp = a <= b;
                ACT_EQ: o.cmp = a == b;
                ACT_NE: o.cmp = a != b;
                ACT_MIN: r = a < b ? a : b;
                ACT_MAX: r = a > b ? a : b;
                ACT_INC: r = a + 1;
                ACT_DEC: r = a - 1;
                ACT_ABS: r = ma;
                ACT_FROM_INT: begin
                    q = ma << FRAC_BITS;
                    r = a < 0 ? -$signed(q) : $signed(q);
                end
                ACT_TO_INT: begin
                    q = ma >> FRAC_BITS;
                    r = a < 0 ? -$signed(q) : $signed(q);
                end
                default: r = 0;
            endcase
            if (act == ACT_DIV && b == 0) begin
                o.st = ST_DIV_ZERO;
                o.res = '0;
            end else begin
                o.res = clamp64(r, o.st);
            end
            return o;
        endfunction

        function void note_input(input logic [4:0] act, input logic [31:0] a,
                                 input logic [31:0] b);
            pending.push_back(compute(act, a, b));
        endfunction

        function void check_result(input t_alu_out got);
            t_alu_out exp_out;
            if (pending.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result word %h", got);
                return;
            end
            exp_out = pending.pop_front();
            if (got !== exp_out) begin
                errors++;
                if (mismatches++ < 10)
                    $display("mismatch: exp res=%h cmp=%b st=%0d got res=%h cmp=%b st=%0d",
                             exp_out.res, exp_out.cmp, exp_out.st,
                             got.res, got.cmp, got.st);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic [4:0] i_action = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic o_valid;
    logic i_ready = 0;
    logic signed [31:0] o_result_value;
    logic o_compare_true;
    logic [1:0] o_status;

    alu_scoreboard sb;
    int idle_cycles = 0;
    bit stim_done = 0;

    fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) u_dut (.*);

    always #5 i_clk = ~i_clk;

    // receiver stall pattern
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            case (stall_mode)
                0: i_ready <= 1;
                1: i_ready <= ($urandom_range(3) != 0);
                2: i_ready <= ($urandom_range(3) == 0);
                default: i_ready <= $urandom_range(1);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result({o_result_value, o_compare_true, o_status});
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (stim_done) stall_mode <= 0;
            else if ($urandom_range(199) == 0) stall_mode <= $urandom_range(3);
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input logic [4:0] act, input logic [31:0] a,
                             input logic [31:0] b);
        i_valid <= 1;
        i_action <= act;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(act, a, b);
    endtask

    task automatic pause_sender();
        int gap;
        gap = $urandom_range(6);
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(4096) - 2048;
            2: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            3: return $urandom_range(1) ? MAX32 - $urandom_range(3) : MIN32 + $urandom_range(3);
            4: return 32'($urandom_range(255)) << 8;
            default: return {{24{$urandom_range(1) == 1}}, 8'($urandom)};
        endcase
    endfunction

    initial begin
        int burst;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // extremes and special cases
        send_word(ACT_ADD, MAX32, 32'd1);
        send_word(ACT_SUB, MIN32, 32'd1);
        send_word(ACT_MUL, 32'h0000_0180, 32'h0000_0080);
        send_word(ACT_MUL, 32'hffff_fe80, 32'h0000_0080);
        send_word(ACT_MUL, MAX32, MAX32);
        send_word(ACT_MUL, MIN32, MIN32);
        send_word(ACT_DIV, 32'd100, 32'd0);
        send_word(ACT_DIV, 32'd1, 32'd512);
        send_word(ACT_DIV, 32'hffff_ffff, 32'd512);
        send_word(ACT_DIV, MIN32, 32'd1);
        send_word(ACT_DIV, MIN32, 32'hffff_ffff);
        send_word(ACT_GT, MAX32, MIN32);
        send_word(ACT_LT, MIN32, MAX32);
        send_word(ACT_GE, 32'd5, 32'd5);
        send_word(ACT_LE, 32'd6, 32'd5);
        send_word(ACT_EQ, MIN32, MIN32);
        send_word(ACT_NE, 32'd0, 32'd0);
        send_word(ACT_MIN, MIN32, MAX32);
        send_word(ACT_MAX, MIN32, MAX32);
        send_word(ACT_INC, MAX32, 32'd0);
        send_word(ACT_DEC, MIN32, 32'd0);
        send_word(ACT_ABS, MIN32, 32'd0);
        send_word(ACT_FROM_INT, 32'h0080_0000, 32'd0);
        send_word(ACT_TO_INT, 32'hffff_fe80, 32'd0);
        send_word(5'd31, MAX32, MAX32);
        for (int i = 0; i < N_RANDOM; ) begin
            burst = $urandom_range(40, 1);
            for (int k = 0; k < burst && i < N_RANDOM; k++, i++)
                send_word($urandom_range(99) < 97 ? 5'($urandom_range(16))
                                                   : 5'($urandom_range(31, 17)),
                          rand_operand(), $urandom_range(19) == 0 ? 32'd0 : rand_operand());
            pause_sender();
        end
        i_valid <= 0;
        stim_done = 1;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: filelist.f
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_div_cell.sv
rtl/fpa_back.sv
rtl/fixed_point_alu.sv
tb/tb_fixed_point_alu.sv
